### design/fwa_pkg.sv
// Package: shared widths, request and status codes, shared-unit types.
package fwa_pkg;

  localparam int VAL_W   = 16;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 5;
  localparam int TOTAL_W = 20;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ENQ  = 2'd1,
    OP_DEQ  = 2'd2,
    OP_AGE  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [VAL_W-1:0] operand;
  } alu_req_t;

endpackage

### design/fwa_in_if.sv
// Request channel: valid/ready handshake with request code and value.
interface fwa_in_if;
  import fwa_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

### design/fwa_out_if.sv
// Result channel: valid/ready handshake with status, value, count and total.
interface fwa_out_if;
  import fwa_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [VAL_W-1:0]   out_value;
  logic [CNT_W-1:0]   count;
  logic               is_empty;
  logic [TOTAL_W-1:0] total_wait;

  modport source (output valid, output status, output out_value, output count,
                  output is_empty, output total_wait, input ready);
  modport sink (input valid, input status, input out_value, input count,
                input is_empty, input total_wait, output ready);
endinterface

### design/fifo_with_wait_aging.sv
// Top level: ring FIFO of wait counters with aging, running total and sequencer.
// Enqueue and empty/full/unknown requests: accept, then S_DONE, then the result register.
// Dequeue adds one RAM read in S_DEQ. Tick sweeps the ring in S_AGE, one entry per cycle
// through the shared increment/total unit and the single RAM write port.
// One request in flight; the next is accepted once the result is registered.
// Synchronous reset empties the ring and clears the total; RAM is not cleared.
module fifo_with_wait_aging #(
  parameter int DEPTH = 16
) (
  input logic clk,
  input logic rst,
  fwa_in_if.sink    in_ch,
  fwa_out_if.source out_ch
);
  import fwa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_AGE  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      count;
  logic [TOTAL_W-1:0] total;
  logic [AW-1:0]      rd_ptr;
  logic [AW-1:0]      wr_ptr;
  logic [CW-1:0]      age_left;
  logic [ST_W-1:0]    status_q;
  logic [VAL_W-1:0]   outv_q;

  logic               accept;
  logic               is_full;
  logic               is_zero;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;
  alu_req_t           alu_req;
  logic [VAL_W-1:0]   alu_entry;
  logic [TOTAL_W-1:0] alu_total;
  logic               out_load;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count == CW'(DEPTH));
  assign is_zero     = (count == '0);
  assign out_load    = (state == S_DONE) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    alu_req.op      = OP_NONE;
    alu_req.operand = ram_rdata;
    case (state)
      S_IDLE: begin
        alu_req.op      = OP_ENQ;
        alu_req.operand = in_ch.value;
      end
      S_DEQ:   alu_req.op = OP_DEQ;
      S_AGE:   alu_req.op = OP_AGE;
      default: alu_req.op = OP_NONE;
    endcase
  end

  fwa_alu u_alu (
    .req        (alu_req),
    .total      (total),
    .entry      (alu_entry),
    .total_next (alu_total)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = in_ch.value;
    ram_raddr = head;
    if (state == S_IDLE) begin
      ram_we = accept && (in_ch.req_type == REQ_ENQUEUE) && !is_full;
    end else if (state == S_AGE) begin
      ram_we    = 1'b1;
      ram_waddr = wr_ptr;
      ram_wdata = alu_entry;
      ram_raddr = rd_ptr;
    end
  end

  fwa_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      total    <= '0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      age_left <= '0;
      status_q <= ST_DONE;
      outv_q   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_q <= ST_DONE;
            outv_q   <= '0;
            state    <= S_DONE;
            case (in_ch.req_type)
              REQ_ENQUEUE: begin
                if (is_full) begin
                  status_q <= ST_FULL;
                end else begin
                  tail  <= ring_next(tail);
                  count <= CW'(count + 1'b1);
                  total <= alu_total;
                end
              end
              REQ_DEQUEUE: begin
                if (is_zero) begin
                  status_q <= ST_EMPTY;
                end else begin
                  state <= S_DEQ;
                end
              end
              REQ_TICK: begin
                if (!is_zero) begin
                  rd_ptr   <= ring_next(head);
                  wr_ptr   <= head;
                  age_left <= count;
                  state    <= S_AGE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DEQ: begin
          outv_q <= ram_rdata;
          total  <= alu_total;
          head   <= ring_next(head);
          count  <= CW'(count - 1'b1);
          state  <= S_DONE;
        end
        S_AGE: begin
          total    <= alu_total;
          wr_ptr   <= ring_next(wr_ptr);
          rd_ptr   <= ring_next(rd_ptr);
          age_left <= CW'(age_left - 1'b1);
          if (age_left == CW'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status     <= status_q;
      out_ch.out_value  <= outv_q;
      out_ch.count      <= CNT_W'(count);
      out_ch.is_empty   <= is_zero;
      out_ch.total_wait <= total;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_age_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) |-> (age_left != '0) && (age_left <= count))
    else $error("aging sweep counter out of range");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && is_zero |-> (total == '0))
    else $error("total nonzero on empty ring");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.req_type == REQ_DEQUEUE) && is_zero
      |=> (state == S_DONE) && (status_q == ST_EMPTY))
    else $error("dequeue on empty not flagged");

endmodule

### design/fwa_ram.sv
// Generic simple dual-port RAM with registered read.
module fwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/fwa_alu.sv
// Shared arithmetic unit: entry increment and running total update.
module fwa_alu (
  input  fwa_pkg::alu_req_t               req,
  input  logic [fwa_pkg::TOTAL_W-1:0]     total,
  output logic [fwa_pkg::VAL_W-1:0]       entry,
  output logic [fwa_pkg::TOTAL_W-1:0]     total_next
);
  import fwa_pkg::*;

  logic [VAL_W-1:0] add;
  logic [VAL_W-1:0] sub;

  always_comb begin
    entry = VAL_W'(req.operand + 1'b1);
    add   = '0;
    sub   = '0;
    case (req.op)
      OP_ENQ: begin
        add = req.operand;
      end
      OP_DEQ: begin
        sub = req.operand;
      end
      OP_AGE: begin
        add = entry;
        sub = req.operand;
      end
      default: begin
        add = '0;
        sub = '0;
      end
    endcase
    total_next = total + TOTAL_W'(add) - TOTAL_W'(sub);
  end
endmodule

### bench/tb_fifo_with_wait_aging.sv
// Testbench: directed table and random request mix against an aging FIFO predictor.
module tb_fifo_with_wait_aging;
  import fwa_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_SHOWN    = 10;
  localparam int IDLE_PCT     = 36;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [VAL_W-1:0]   out_value;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic [TOTAL_W-1:0] total_wait;
  } wait_result_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [VAL_W-1:0] value;
    bit               known;
    wait_result_t     known_res;
  } stim_row_t;

  logic clk;
  logic rst;

  fwa_in_if  in_ch();
  fwa_out_if out_ch();

  fifo_with_wait_aging #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  logic [VAL_W-1:0] ring_model [DEPTH];
  int               model_head  = 0;
  int               model_tail  = 0;
  int               model_count = 0;

  wait_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int           mismatches   = 0;
  int           stall_cycles = 0;
  bit           no_idle      = 1'b0;

  function automatic wait_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic [VAL_W-1:0] val);
    wait_result_t       r;
    logic [TOTAL_W-1:0] sum;
    int                 pos;
    int                 n;
    r = '0;
    r.status = ST_DONE;
    case (req)
      REQ_ENQUEUE: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_model[model_tail] = val;
          model_tail = (model_tail + 1) % DEPTH;
          model_count++;
        end
      end
      REQ_DEQUEUE: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = ring_model[model_head];
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      REQ_TICK: begin
        pos = model_head;
        for (n = 0; n < model_count; n++) begin
          ring_model[pos] = ring_model[pos] + 1'b1;
          pos = (pos + 1) % DEPTH;
        end
      end
      default: ;
    endcase
    sum = '0;
    pos = model_head;
    for (n = 0; n < model_count; n++) begin
      sum += ring_model[pos];
      pos = (pos + 1) % DEPTH;
    end
    r.count      = model_count[CNT_W-1:0];
    r.is_empty   = (model_count == 0);
    r.total_wait = sum;
    return r;
  endfunction

  function automatic wait_result_t mk_result(input logic [ST_W-1:0] st,
                                             input logic [VAL_W-1:0] ov,
                                             input logic [CNT_W-1:0] cnt,
                                             input logic emp,
                                             input logic [TOTAL_W-1:0] tot);
    wait_result_t r;
    r.status     = st;
    r.out_value  = ov;
    r.count      = cnt;
    r.is_empty   = emp;
    r.total_wait = tot;
    return r;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val,
                         input bit known, input wait_result_t res);
    stim_row_t row;
    row.req       = req;
    row.value     = val;
    row.known     = known;
    row.known_res = res;
    directed_rows.push_back(row);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'hFFF0 | 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_req(input req_mix_t mix);
    int roll;
    int enq_lim;
    int deq_lim;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        enq_lim = 60;
        deq_lim = 80;
      end
      MIX_DRAIN: begin
        enq_lim = 20;
        deq_lim = 80;
      end
      default: begin
        enq_lim = 40;
        deq_lim = 75;
      end
    endcase
    if (roll < enq_lim) return REQ_ENQUEUE;
    if (roll < deq_lim) return REQ_DEQUEUE;
    if (roll < 95) return REQ_TICK;
    return REQ_UNUSED;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val,
                               input bit known, input wait_result_t known_res);
    wait_result_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(req, val);
    pending_results.push_back(known ? known_res : predicted);
    @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    wait_result_t got;
    wait_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = mk_result(out_ch.status, out_ch.out_value, out_ch.count, out_ch.is_empty,
                      out_ch.total_wait);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: status %0d out_value %h count %0d total_wait %h",
                   got.status, got.out_value, got.count, got.total_wait);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.out_value !== want.out_value ||
            got.count !== want.count || got.is_empty !== want.is_empty ||
            got.total_wait !== want.total_wait) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display(
              "mismatch exp/got: st %0d/%0d val %h/%h cnt %0d/%0d emp %0d/%0d tot %h/%h",
              want.status, got.status, want.out_value, got.out_value,
              want.count, got.count, want.is_empty, got.is_empty,
              want.total_wait, got.total_wait);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int       i;
    req_mix_t mix;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_ENQUEUE;
    in_ch.value    = '0;

    add_row(REQ_DEQUEUE, 16'h0000, 1, mk_result(ST_EMPTY, 16'h0, 5'd0, 1'b1, 20'h0));
    add_row(REQ_TICK,    16'h0000, 1, mk_result(ST_DONE, 16'h0, 5'd0, 1'b1, 20'h0));
    add_row(REQ_UNUSED,  16'hFFFF, 1, mk_result(ST_DONE, 16'h0, 5'd0, 1'b1, 20'h0));
    add_row(REQ_ENQUEUE, 16'hFFFF, 1, mk_result(ST_DONE, 16'h0, 5'd1, 1'b0, 20'h0FFFF));
    // tick wraps the stored entry to zero
    add_row(REQ_TICK,    16'h0000, 1, mk_result(ST_DONE, 16'h0, 5'd1, 1'b0, 20'h0));
    add_row(REQ_DEQUEUE, 16'h5555, 1, mk_result(ST_DONE, 16'h0, 5'd0, 1'b1, 20'h0));
    for (i = 0; i < DEPTH - 1; i++)
      add_row(REQ_ENQUEUE, 16'hFFFF, 0, '0);
    add_row(REQ_ENQUEUE, 16'hFFFF, 1, mk_result(ST_DONE, 16'h0, 5'd16, 1'b0, 20'hFFFF0));
    add_row(REQ_ENQUEUE, 16'h1234, 1, mk_result(ST_FULL, 16'h0, 5'd16, 1'b0, 20'hFFFF0));
    add_row(REQ_UNUSED,  16'hAAAA, 1, mk_result(ST_DONE, 16'h0, 5'd16, 1'b0, 20'hFFFF0));
    add_row(REQ_TICK,    16'h0000, 0, '0);
    add_row(REQ_DEQUEUE, 16'h0000, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      issue_request(directed_rows[k].req, directed_rows[k].value,
                    directed_rows[k].known, directed_rows[k].known_res);

    mix = MIX_EVEN;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0)
        mix = req_mix_t'($urandom_range(2));
      no_idle = (i >= 600 && i < 900);
      if (i == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      issue_request(pick_req(mix), pick_value(), 0, '0);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
design/fwa_pkg.sv
design/fwa_in_if.sv
design/fwa_out_if.sv
design/fwa_ram.sv
design/fwa_alu.sv
design/fifo_with_wait_aging.sv
bench/tb_fifo_with_wait_aging.sv
